/* rtl/core/dsel_pkg.sv */
// Shared types and constants for the DER sequence element locator.
package dsel_pkg;

  // Longest long-form length field, in bytes.
  localparam int unsigned MAX_LEN_BYTES = 4;

  localparam logic [7:0] SEQUENCE_TAG = 8'h30;
  localparam logic [7:0] LONG_FORM_BIT = 8'h80;

  // Result codes.
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_BAD_TAG   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_BAD_FORM  = 3'd4
  } dsel_status_t;

  // One input beat.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] buffer_length;
    logic [31:0] target_index;
  } dsel_beat_t;

  // One result beat.
  typedef struct packed {
    dsel_status_t status;
    logic [31:0]  element_offset;
    logic [31:0]  element_length;
  } dsel_result_t;

endpackage

/* rtl/core/dsel_in_stage.sv */
// Input register stage of the DER sequence element locator.
module dsel_in_stage import dsel_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dsel_beat_t item_beat,
  input  logic       advance,
  output logic       q_valid,
  output dsel_beat_t q_beat
);

  // Hold the registered beat while the parse stage cannot take it.
  assign item_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!item_stall) begin
      q_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      q_beat <= item_beat;
    end
  end

endmodule

/* rtl/core/dsel_parse.sv */
// Parse state and combinational next-state logic of the DER sequence walker.
module dsel_parse import dsel_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  dsel_beat_t   beat,
  output logic         res_valid,
  output dsel_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OUTER_LEN,
    PH_OUTER_LONG,
    PH_CHILD_TAG,
    PH_CHILD_LEN,
    PH_CHILD_LONG,
    PH_SKIP
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [31:0] outer_length, outer_length_next;
  logic [31:0] elements_seen, elements_seen_next;
  logic [31:0] wanted_index, wanted_index_next;
  logic [31:0] buffer_size, buffer_size_next;
  logic [31:0] element_start, element_start_next;
  logic [31:0] content_skip_left, content_skip_left_next;
  logic        search_done, search_done_next;

  // Next-state and result logic for one byte.
  always_comb begin
    logic [32:0] next_off;
    logic [32:0] bsize;
    logic [32:0] room;
    logic [33:0] total;
    logic [6:0]  n_bytes;
    logic        do_outer;
    logic        do_child;
    logic        do_begin;
    logic [31:0] len_val;

    parse_phase_next        = parse_phase;
    byte_position_next      = byte_position;
    length_bytes_left_next  = length_bytes_left;
    length_accumulator_next = length_accumulator;
    outer_length_next       = outer_length;
    elements_seen_next      = elements_seen;
    wanted_index_next       = wanted_index;
    buffer_size_next        = buffer_size;
    element_start_next      = element_start;
    content_skip_left_next  = content_skip_left;
    search_done_next        = search_done;
    res_valid               = 1'b0;
    res.status              = ST_FOUND;
    res.element_offset      = '0;
    res.element_length      = '0;

    next_off = {1'b0, byte_position} + 33'd1;
    bsize    = {1'b0, buffer_size};
    room     = bsize - next_off;
    total    = '0;
    n_bytes  = beat.data_byte[6:0];
    do_outer = 1'b0;
    do_child = 1'b0;
    do_begin = 1'b0;
    len_val  = '0;

    if (beat.first_byte) begin
      // A tag byte always starts a new search.
      buffer_size_next   = beat.buffer_length;
      wanted_index_next  = beat.target_index;
      byte_position_next = 32'd1;
      search_done_next   = 1'b0;
      elements_seen_next = '0;
      if (beat.buffer_length < 32'd2) begin
        res_valid = 1'b1;
        res.status = ST_TRUNC;
      end else if (beat.data_byte != SEQUENCE_TAG) begin
        res_valid = 1'b1;
        res.status = ST_BAD_TAG;
      end else begin
        parse_phase_next = PH_OUTER_LEN;
      end
    end else if (!search_done) begin
      byte_position_next = next_off[31:0];
      unique case (parse_phase)
        PH_OUTER_LEN, PH_CHILD_LEN: begin
          // Length-form byte: short form, or the count of length bytes.
          if (!beat.data_byte[7]) begin
            len_val = {24'd0, beat.data_byte};
            do_outer = (parse_phase == PH_OUTER_LEN);
            do_child = (parse_phase == PH_CHILD_LEN);
          end else if (beat.data_byte == LONG_FORM_BIT ||
                       n_bytes > 7'(MAX_LEN_BYTES)) begin
            res_valid = 1'b1;
            res.status = ST_BAD_FORM;
          end else if (next_off + 33'(n_bytes) > bsize) begin
            res_valid = 1'b1;
            res.status = ST_TRUNC;
          end else begin
            length_bytes_left_next  = n_bytes[2:0];
            length_accumulator_next = '0;
            parse_phase_next = (parse_phase == PH_OUTER_LEN) ? PH_OUTER_LONG
                                                             : PH_CHILD_LONG;
          end
        end
        PH_OUTER_LONG, PH_CHILD_LONG: begin
          // Shift in one long-form length byte.
          length_accumulator_next = {length_accumulator[23:0], beat.data_byte};
          length_bytes_left_next  = length_bytes_left - 3'd1;
          if (length_bytes_left_next == 3'd0) begin
            len_val  = length_accumulator_next;
            do_outer = (parse_phase == PH_OUTER_LONG);
            do_child = (parse_phase == PH_CHILD_LONG);
          end
        end
        PH_CHILD_TAG: begin
          element_start_next = byte_position;
          if (next_off >= bsize) begin
            res_valid = 1'b1;
            res.status = ST_TRUNC;
          end else begin
            parse_phase_next = PH_CHILD_LEN;
          end
        end
        PH_SKIP: begin
          content_skip_left_next = content_skip_left - 32'd1;
          do_begin = (content_skip_left_next == '0);
        end
        default: begin
          search_done_next = 1'b1;
          parse_phase_next = PH_IDLE;
        end
      endcase

      // Outer length known: it must fit in the rest of the buffer.
      if (do_outer) begin
        outer_length_next = len_val;
        if (next_off <= bsize && {1'b0, len_val} > room) begin
          res_valid = 1'b1;
          res.status = ST_TOO_LONG;
        end else begin
          elements_seen_next = '0;
          do_begin = 1'b1;
        end
      end

      // Child length known: report it, or skip its content.
      if (do_child) begin
        if (elements_seen == wanted_index) begin
          total = {1'b0, next_off} - {2'b00, element_start} + {2'b00, len_val};
          res_valid = 1'b1;
          res.status = ST_FOUND;
          res.element_offset = element_start;
          res.element_length = (total[33:32] != 2'b00) ? '1 : total[31:0];
        end else if (next_off + {1'b0, len_val} > bsize) begin
          res_valid = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          elements_seen_next = elements_seen + 32'd1;
          if (len_val == '0) begin
            do_begin = 1'b1;
          end else begin
            content_skip_left_next = len_val;
            parse_phase_next = PH_SKIP;
          end
        end
      end

      // The next child tag must lie inside the buffer.
      if (do_begin) begin
        if (next_off >= bsize) begin
          res_valid = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          parse_phase_next = PH_CHILD_TAG;
        end
      end
    end

    // Any result ends the search.
    if (res_valid) begin
      search_done_next = 1'b1;
      parse_phase_next = PH_IDLE;
    end
    res_valid = res_valid && fire;
  end

  // Parse state registers, updated once per consumed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_IDLE;
      byte_position      <= '0;
      length_bytes_left  <= '0;
      length_accumulator <= '0;
      outer_length       <= '0;
      elements_seen      <= '0;
      wanted_index       <= '0;
      buffer_size        <= '0;
      element_start      <= '0;
      content_skip_left  <= '0;
      search_done        <= 1'b1;
    end else if (fire) begin
      parse_phase        <= parse_phase_next;
      byte_position      <= byte_position_next;
      length_bytes_left  <= length_bytes_left_next;
      length_accumulator <= length_accumulator_next;
      outer_length       <= outer_length_next;
      elements_seen      <= elements_seen_next;
      wanted_index       <= wanted_index_next;
      buffer_size        <= buffer_size_next;
      element_start      <= element_start_next;
      content_skip_left  <= content_skip_left_next;
      search_done        <= search_done_next;
    end
  end

endmodule

/* rtl/core/dsel_out_stage.sv */
// Result register stage of the DER sequence element locator.
module dsel_out_stage import dsel_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  input  dsel_result_t res,
  output logic         advance,
  output logic         result_valid,
  input  logic         result_stall,
  output dsel_result_t result
);

  // The register can load when it is empty or its beat leaves this cycle.
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_valid;
    end
    if (advance && res_valid) begin
      result <= res;
    end
  end

endmodule

/* rtl/core/der_sequence_element_locator_top.sv */
// Top level of the DER sequence element locator.
//
// Bytes of a DER SEQUENCE enter one per beat on the item channel, the tag
// byte marked by first_byte together with the buffer size and the wanted
// child index. The block takes one byte per clock cycle, back to back,
// while the result channel is not stalled, and returns at most one result
// per search on the result channel: the wanted child's tag offset and total
// encoded length, or an error code. A byte is held in the input register,
// is parsed by the walker state logic, and its result, if any, is loaded
// into the result register. A stall on the result side holds the pipeline;
// the input register keeps accepting until it is full.
module der_sequence_element_locator_top import dsel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [31:0] buffer_length,
  input  logic [31:0] target_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [31:0] element_offset,
  output logic [31:0] element_length
);

  dsel_beat_t   item_beat;
  dsel_beat_t   q_beat;
  logic         q_valid;
  logic         advance;
  logic         res_valid;
  dsel_result_t res;
  dsel_result_t result;

  assign item_beat.data_byte     = data_byte;
  assign item_beat.first_byte    = first_byte;
  assign item_beat.buffer_length = buffer_length;
  assign item_beat.target_index  = target_index;

  dsel_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item_beat (item_beat),
    .advance   (advance),
    .q_valid   (q_valid),
    .q_beat    (q_beat)
  );

  dsel_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .fire     (q_valid && advance),
    .beat     (q_beat),
    .res_valid(res_valid),
    .res      (res)
  );

  dsel_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .advance     (advance),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  assign status         = result.status;
  assign element_offset = result.element_offset;
  assign element_length = result.element_length;

endmodule

/* rtl/core/dsel_checker.sv */
// Port-level checks for the DER sequence element locator.
module dsel_checker import dsel_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [31:0] element_offset,
  input logic [31:0] element_length
);

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // A stalled result beat stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result beat dropped");

  // An error result carries no offset or length.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_FOUND |->
      element_offset == '0 && element_length == '0)
    else $error("error result with nonzero offset or length");

  // A found element spans at least its tag and one length byte.
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FOUND |-> element_length >= 32'd2)
    else $error("found element shorter than its header");

endmodule

bind der_sequence_element_locator_top dsel_checker u_chk (.*);

/* tb/testbench.sv */
// Self-checking testbench for the DER sequence element locator.
`timescale 1ns / 100ps

module testbench import dsel_pkg::*;;

  localparam int unsigned RANDOM_BEATS   = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef logic [7:0] octet_q_t[$];

  // Where the search walk stands after a beat.
  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_OUTER_LEN,
    WALK_OUTER_LONG,
    WALK_CHILD_TAG,
    WALK_CHILD_LEN,
    WALK_CHILD_LONG,
    WALK_SKIP
  } walk_phase_t;

  // Tracks the search walk beat by beat and holds the lookups still owed by the block.
  class lookup_scoreboard;
    walk_phase_t  phase;
    logic [31:0]  position;
    logic [2:0]   len_left;
    logic [31:0]  accum;
    logic [31:0]  outer_len;
    logic [31:0]  seen;
    logic [31:0]  wanted;
    logic [31:0]  buf_size;
    logic [31:0]  elem_start;
    logic [31:0]  skip_left;
    bit           search_idle;
    dsel_result_t pending_lookups[$];
    int unsigned  mismatches;
    int unsigned  results_checked;

    function new();
      phase = WALK_IDLE;
      position = '0;
      len_left = '0;
      accum = '0;
      outer_len = '0;
      seen = '0;
      wanted = '0;
      buf_size = '0;
      elem_start = '0;
      skip_left = '0;
      search_idle = 1'b1;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function int unsigned pending();
      return pending_lookups.size();
    endfunction

    function bit searching();
      return !search_idle;
    endfunction

    // Ends the search with one result.
    function void close_search(dsel_status_t st, logic [31:0] off, logic [31:0] len);
      dsel_result_t r;
      r.status = st;
      r.element_offset = off;
      r.element_length = len;
      pending_lookups.push_back(r);
      search_idle = 1'b1;
      phase = WALK_IDLE;
    endfunction

    // The next child tag is needed at offset off.
    function void want_child_tag(longint unsigned off);
      if (off >= 64'(buf_size)) begin
        close_search(ST_TRUNC, '0, '0);
      end else begin
        phase = WALK_CHILD_TAG;
      end
    endfunction

    function void outer_complete(longint unsigned off);
      if (64'(outer_len) > 64'(buf_size) - off) begin
        close_search(ST_TOO_LONG, '0, '0);
      end else begin
        seen = '0;
        want_child_tag(off);
      end
    endfunction

    // A child header is complete; its content starts at off.
    function void child_complete(longint unsigned off, logic [31:0] len);
      longint unsigned total;
      if (seen == wanted) begin
        total = off - 64'(elem_start) + 64'(len);
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        close_search(ST_FOUND, elem_start, total[31:0]);
      end else if (off + 64'(len) > 64'(buf_size)) begin
        close_search(ST_TRUNC, '0, '0);
      end else begin
        seen = seen + 32'd1;
        if (len == 0) begin
          want_child_tag(off);
        end else begin
          skip_left = len;
          phase = WALK_SKIP;
        end
      end
    endfunction

    // Handles the first byte of a length field, outer or child.
    function void length_form(logic [7:0] b, longint unsigned next, bit is_outer);
      int unsigned n;
      if (b < LONG_FORM_BIT) begin
        if (is_outer) begin
          outer_len = 32'(b);
          outer_complete(next);
        end else begin
          child_complete(next, 32'(b));
        end
      end else if (b == LONG_FORM_BIT) begin
        close_search(ST_BAD_FORM, '0, '0);
      end else begin
        n = 32'(b) - 32'(LONG_FORM_BIT);
        if (n > MAX_LEN_BYTES) begin
          close_search(ST_BAD_FORM, '0, '0);
        end else if (next + 64'(n) > 64'(buf_size)) begin
          close_search(ST_TRUNC, '0, '0);
        end else begin
          len_left = n[2:0];
          accum = '0;
          phase = is_outer ? WALK_OUTER_LONG : WALK_CHILD_LONG;
        end
      end
    endfunction

    // Advances the walk by one accepted beat; returns 0 when the block ignores it.
    function bit walk_byte(logic [7:0] b, logic fb, logic [31:0] bl, logic [31:0] ti);
      longint unsigned pos;
      longint unsigned next;
      if (fb) begin
        buf_size = bl;
        wanted = ti;
        position = 32'd1;
        search_idle = 1'b0;
        seen = '0;
        if (buf_size < 2) begin
          close_search(ST_TRUNC, '0, '0);
        end else if (b != SEQUENCE_TAG) begin
          close_search(ST_BAD_TAG, '0, '0);
        end else begin
          phase = WALK_OUTER_LEN;
        end
        return 1'b1;
      end
      if (search_idle) return 1'b0;

      pos = 64'(position);
      next = pos + 1;
      position = next[31:0];
      case (phase)
        WALK_OUTER_LEN: length_form(b, next, 1'b1);
        WALK_OUTER_LONG, WALK_CHILD_LONG: begin
          accum = {accum[23:0], b};
          len_left = len_left - 3'd1;
          if (len_left == 0) begin
            if (phase == WALK_OUTER_LONG) begin
              outer_len = accum;
              outer_complete(next);
            end else begin
              child_complete(next, accum);
            end
          end
        end
        WALK_CHILD_TAG: begin
          elem_start = pos[31:0];
          if (next >= 64'(buf_size)) begin
            close_search(ST_TRUNC, '0, '0);
          end else begin
            phase = WALK_CHILD_LEN;
          end
        end
        WALK_CHILD_LEN: length_form(b, next, 1'b0);
        WALK_SKIP: begin
          skip_left = skip_left - 32'd1;
          if (skip_left == 0) want_child_tag(next);
        end
        default: begin
          search_idle = 1'b1;
          phase = WALK_IDLE;
        end
      endcase
      return 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] lookup mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compares one accepted result beat with the oldest owed lookup.
    task check_result(logic [2:0] got_status, logic [31:0] got_offset,
                      logic [31:0] got_length);
      dsel_result_t want;
      results_checked++;
      if (pending_lookups.size() == 0) begin
        report($sformatf("result %0d (status %0d offset %0d length %0d) with none owed",
                         results_checked, got_status, got_offset, got_length));
        return;
      end
      want = pending_lookups.pop_front();
      if (got_status !== want.status)
        report($sformatf("result %0d status %0d, wanted %0d",
                         results_checked, got_status, want.status));
      if (got_offset !== want.element_offset)
        report($sformatf("result %0d element_offset %0d, wanted %0d",
                         results_checked, got_offset, want.element_offset));
      if (got_length !== want.element_length)
        report($sformatf("result %0d element_length %0d, wanted %0d",
                         results_checked, got_length, want.element_length));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic [31:0] buffer_length = '0;
  logic [31:0] target_index = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] element_offset;
  logic [31:0] element_length;

  lookup_scoreboard lookups;
  int unsigned      walked_beats = 0;
  int unsigned      burst_left = 0;
  int unsigned      stall_run = 0;
  int unsigned      stall_mode = 0;
  int unsigned      quiet_cycles = 0;
  bit               drained_once = 1'b0;

  der_sequence_element_locator_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .buffer_length (buffer_length),
    .target_index  (target_index),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .element_offset(element_offset),
    .element_length(element_length)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result-side stall pattern: stretches of none, light, heavy and periodic stalling.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= ((stall_run % 16) < 10);
    endcase
  end

  // Every accepted result beat is checked against the oldest owed lookup.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      lookups.check_result(status, element_offset, element_length);
  end

  // The run is ended when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no beat moved for %0d cycles", $realtime, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drives one beat in bursts with random gaps, and waits for it to be taken.
  task automatic drive_byte(input logic [7:0] b, input bit fb, input logic [31:0] bl,
                            input logic [31:0] ti);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 24);
    end
    item_valid <= 1'b1;
    data_byte <= b;
    first_byte <= fb;
    buffer_length <= bl;
    target_index <= ti;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    if (lookups.walk_byte(b, fb, bl, ti)) walked_beats++;
  endtask

  // Sends an encoding; the tail after the result is dropped unless keep_tail is set.
  task automatic send_octets(input octet_q_t seq, input logic [31:0] bl,
                             input logic [31:0] ti, input bit keep_tail);
    foreach (seq[i]) begin
      drive_byte(seq[i], i == 0, (i == 0) ? bl : 32'($urandom()), (i == 0) ? ti : 32'($urandom()));
      if (!keep_tail && !lookups.searching()) break;
    end
  endtask

  // Appends a DER length field, in long form when min_octets is nonzero or len is 128 or more.
  function automatic void put_length(ref octet_q_t q, input int unsigned len,
                                     input int unsigned min_octets);
    int unsigned n;
    if (len < 128 && min_octets == 0) begin
      q.push_back(len[7:0]);
      return;
    end
    n = 1;
    while (n < 4 && (len >> (8 * n)) != 0) n++;
    if (n < min_octets) n = min_octets;
    q.push_back(LONG_FORM_BIT | 8'(n));
    for (int k = n; k > 0; k--) q.push_back(8'(len >> (8 * (k - 1))));
  endfunction

  // Builds a sequence of random children, mostly intact, sometimes damaged.
  task automatic send_random_sequence();
    octet_q_t    body;
    octet_q_t    seq;
    int unsigned kids;
    int unsigned clen;
    int unsigned pick;
    logic [31:0] bl;
    logic [31:0] ti;
    kids = $urandom_range(0, 4);
    for (int k = 0; k < kids; k++) begin
      body.push_back(8'($urandom()));
      pick = $urandom_range(0, 19);
      clen = (pick == 0) ? $urandom_range(120, 160) : (pick < 6) ? 0 : $urandom_range(1, 10);
      put_length(body, clen, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
      repeat (clen) body.push_back(8'($urandom()));
    end
    // A child that claims a huge content it never carries.
    if ($urandom_range(0, 9) == 0) begin
      body.push_back(8'($urandom()));
      body.push_back(LONG_FORM_BIT | 8'd4);
      repeat (4) body.push_back(8'($urandom()));
      kids++;
    end
    seq.push_back(SEQUENCE_TAG);
    put_length(seq, body.size(), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
    seq = {seq, body};
    bl = seq.size();
    ti = ($urandom_range(0, 15) == 0) ? 32'($urandom()) : 32'($urandom_range(0, kids));
    case ($urandom_range(0, 11))
      0: bl = $urandom_range(0, seq.size());
      1: bl = $urandom();
      2: bl = seq.size() + $urandom_range(1, 8);
      3: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom());
      4: seq[1] = $urandom_range(0, 1) ? LONG_FORM_BIT : 8'($urandom_range(8'h85, 8'hFF));
      5: seq = seq[0:$urandom_range(0, seq.size() - 1)];
      default: ;
    endcase
    send_octets(seq, bl, ti, $urandom_range(0, 3) == 0);
  endtask

  // Short runs of unstructured beats.
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      drive_byte($urandom_range(0, 1) ? SEQUENCE_TAG : 8'($urandom()),
                 $urandom_range(0, 3) == 0, $urandom(), $urandom());
  endtask

  // Holds the item channel idle until every owed lookup has come back.
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (lookups.pending() != 0);
  endtask

  initial begin
    octet_q_t pattern;
    lookups = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed cases.
    drive_byte(8'hA5, 1'b0, '1, '1);  // no search active: ignored
    pattern = {SEQUENCE_TAG};
    send_octets(pattern, 32'd0, 32'd0, 1'b1);  // empty buffer
    pattern = {8'h31};
    send_octets(pattern, 32'd16, 32'hFFFF_FFFF, 1'b1);  // wrong outer tag
    pattern = {SEQUENCE_TAG, 8'h80};
    send_octets(pattern, 32'd16, 32'd0, 1'b1);  // indefinite form
    pattern = {SEQUENCE_TAG, 8'h85};
    send_octets(pattern, 32'd16, 32'd0, 1'b1);  // too many length bytes
    pattern = {SEQUENCE_TAG, 8'h82};
    send_octets(pattern, 32'd3, 32'd0, 1'b1);  // length bytes past the buffer end
    pattern = {SEQUENCE_TAG, 8'h05};
    send_octets(pattern, 32'd4, 32'd0, 1'b1);  // outer length exceeds the buffer
    pattern = {SEQUENCE_TAG, 8'h00};
    send_octets(pattern, 32'd2, 32'd0, 1'b1);  // no room for a child tag
    pattern = {SEQUENCE_TAG, 8'h06};
    send_octets(pattern, 32'd8, 32'd0, 1'b1);  // abandoned by the next tag
    pattern = {SEQUENCE_TAG, 8'h03, 8'h02, 8'h01, 8'h05};
    send_octets(pattern, 32'd5, 32'd0, 1'b1);  // first child found
    pattern = {SEQUENCE_TAG, 8'h00, 8'h04, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_octets(pattern, 32'hFFFF_FFFF, 32'd0, 1'b1);  // saturated element length

    // Random part.
    walked_beats = 0;
    while (walked_beats < RANDOM_BEATS) begin
      if ((!drained_once && walked_beats >= RANDOM_BEATS / 2) || $urandom_range(0, 39) == 0) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        send_noise();
      end else begin
        send_random_sequence();
      end
    end
    item_valid <= 1'b0;

    while (lookups.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lookups.pending() != 0)
      lookups.report($sformatf("%0d lookups never returned", lookups.pending()));
    if (lookups.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
